// ===== hdl/premultiply_mip_downsampler_core_defines.svh =====
// Assertion macros used by the port checker of the mip downsampler.
`ifndef PREMULTIPLY_MIP_DOWNSAMPLER_CORE_DEFINES_SVH
`define PREMULTIPLY_MIP_DOWNSAMPLER_CORE_DEFINES_SVH

// Checked only outside reset.
`define PMD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pmd check failed");

// Checked on every edge, reset included.
`define PMD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pmd check failed");

`endif

// ===== hdl/pmd_pkg.sv =====
// Shared constants and lane arithmetic of the mip downsampler.
package pmd_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int ROW_W         = 12;
  localparam int PAIR_W        = 36;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 13;
  localparam int COORD_W       = 11;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREMULTIPLY  = 2'd2;

  // Rounded divide by 255 of a lane product: (prod + 127) / 255.
  function automatic logic [7:0] div255_round(input logic [15:0] prod);
    logic [16:0] t;
    logic [16:0] s;
    t = {1'b0, prod} + 17'd127;
    s = t + (t >> 8) + 17'd1;
    return s[15:8];
  endfunction

  // Four 9-bit sums of matching byte lanes.
  function automatic logic [PAIR_W-1:0] lane_pair(input logic [31:0] a,
                                                  input logic [31:0] b);
    logic [PAIR_W-1:0] s;
    s = '0;
    for (int i = 0; i < 4; i++) begin
      s[9*i +: 9] = {1'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8]};
    end
    return s;
  endfunction

  // Per-lane (top + bottom + 2) / 4.
  function automatic logic [31:0] block_average(input logic [PAIR_W-1:0] top,
                                                input logic [PAIR_W-1:0] bot);
    logic [31:0] r;
    logic [9:0]  s;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      s = {1'b0, top[9*i +: 9]} + {1'b0, bot[9*i +: 9]} + 10'd2;
      r[8*i +: 8] = s[9:2];
    end
    return r;
  endfunction

endpackage

// ===== hdl/premultiply_mip_downsampler_core.sv =====
// Top level of the premultiplying 2x2 box-filter mip downsampler.
// Takes ARGB pixels in raster order, one per clock, and emits the half-size level: one
// output per 2x2 block, leaving with its bottom-right source pixel (edge pixels reused on
// an odd last column or row). Colour is premultiplied by alpha when enabled. The pipeline
// is an input stage with the lane multipliers, the stage that reads the pair-sum line
// store (one write and one read per cycle while not stalled, (MAX_WIDTH+1)/2 entries of
// 36 bits, no clearing pass) and an output register with a skid entry. Input runs at one
// transaction per clock and stalls only while the skid entry holds a result left behind by
// output back-pressure. A write to a defined register restarts the frame; write only while
// idle.
module premultiply_mip_downsampler_core #(
  parameter int MAX_WIDTH = pmd_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [31:0]                    s_tdata,  // pixel_in[31:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [55:0]                    m_tdata,  // pixel_out[31:0], out_column[42:32],
                                                   // out_row[53:43], zero pad
  output logic                           m_tlast,  // frame_last
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int XW         = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int YW         = pmd_pkg::ROW_W;
  localparam int CW         = pmd_pkg::COORD_W;
  localparam int PW         = pmd_pkg::PAIR_W;

  // Configuration
  logic [XW-1:0] last_col;
  logic [YW-1:0] last_row;
  logic          premul_en;
  logic          cfg_hit;

  // Position counters
  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic          at_last_col;
  logic          at_last_row;

  // Input stage
  logic          a_valid;
  logic [31:0]   a_pix;
  logic [15:0]   a_prod [3];
  logic [15:0]   prod_in [3];
  logic [AW-1:0] a_idx;
  logic [CW-1:0] a_ocol;
  logic [CW-1:0] a_orow;
  logic          a_hold;
  logic          a_wr;
  logic          a_self;
  logic          a_top_self;
  logic          a_last;

  // Line store stage
  logic          b_valid;
  logic [31:0]   b_pix;
  logic [15:0]   b_prod [3];
  logic [AW-1:0] b_idx;
  logic [CW-1:0] b_ocol;
  logic [CW-1:0] b_orow;
  logic          b_hold;
  logic          b_wr;
  logic          b_self;
  logic          b_top_self;
  logic          b_last;
  logic [31:0]   held;
  logic [31:0]   p;
  logic [31:0]   left;
  logic [PW-1:0] ps;
  logic [PW-1:0] top;
  logic [PW-1:0] line_rd;
  logic          res_valid;
  logic [55:0]   res_data;

  // Output register and skid entry
  logic          skid_valid;
  logic [55:0]   skid_data;
  logic          skid_last;
  logic          adv;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index == pmd_pkg::REG_IMAGE_WIDTH ||
                                   cfg_index == pmd_pkg::REG_IMAGE_HEIGHT ||
                                   cfg_index == pmd_pkg::REG_PREMULTIPLY);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col  <= '0;
      last_row  <= '0;
      premul_en <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pmd_pkg::REG_IMAGE_WIDTH: begin
          if (cfg_data == '0) begin
            last_col <= '0;
          end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
            last_col <= XW'(MAX_WIDTH - 1);
          end else begin
            last_col <= XW'(cfg_data - 13'd1);
          end
        end
        pmd_pkg::REG_IMAGE_HEIGHT: begin
          if (cfg_data == '0) begin
            last_row <= '0;
          end else if (32'(cfg_data) > 32'(pmd_pkg::MAX_HEIGHT)) begin
            last_row <= YW'(pmd_pkg::MAX_HEIGHT - 1);
          end else begin
            last_row <= YW'(cfg_data - 13'd1);
          end
        end
        pmd_pkg::REG_PREMULTIPLY: begin
          premul_en <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline moves whenever the skid entry is free.
  assign adv      = !skid_valid;
  assign s_tready = adv;

  assign at_last_col = (col == last_col);
  assign at_last_row = (row == last_row);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col <= '0;
      row <= '0;
    end else if (s_tvalid && s_tready) begin
      if (at_last_col) begin
        col <= '0;
        row <= at_last_row ? '0 : row + YW'(1);
      end else begin
        col <= col + XW'(1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_in[i] = s_tdata[8*i +: 8] * s_tdata[31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= s_tvalid;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pix      <= s_tdata;
      a_prod     <= prod_in;
      a_idx      <= AW'(col >> 1);
      a_ocol     <= CW'(col >> 1);
      a_orow     <= CW'(row >> 1);
      a_hold     <= !col[0] && !at_last_col;
      a_wr       <= !(!col[0] && !at_last_col) && !row[0] && !at_last_row;
      a_self     <= !col[0];
      a_top_self <= !row[0];
      a_last     <= at_last_col && at_last_row;

      b_pix      <= a_pix;
      b_prod     <= a_prod;
      b_idx      <= a_idx;
      b_ocol     <= a_ocol;
      b_orow     <= a_orow;
      b_hold     <= a_hold;
      b_wr       <= a_wr;
      b_self     <= a_self;
      b_top_self <= a_top_self;
      b_last     <= a_last;
    end
  end

  pmd_line_store #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW),
    .DW    (PW)
  ) u_line (
    .clk     (clk),
    .en      (adv),
    .wr_en   (b_valid && b_wr),
    .wr_addr (b_idx),
    .wr_data (ps),
    .rd_addr (a_idx),
    .rd_data (line_rd)
  );

  always_comb begin
    p = b_pix;
    if (premul_en) begin
      for (int i = 0; i < 3; i++) begin
        p[8*i +: 8] = pmd_pkg::div255_round(b_prod[i]);
      end
    end
    left      = b_self ? p : held;
    ps        = pmd_pkg::lane_pair(left, p);
    top       = b_top_self ? ps : line_rd;
    res_valid = b_valid && !b_hold && !b_wr;
    res_data  = {2'b00, b_orow, b_ocol, pmd_pkg::block_average(top, ps)};
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      held <= '0;
    end else if (adv && b_valid && b_hold) begin
      held <= p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (m_tready || !m_tvalid) begin
        if (skid_valid) begin
          m_tvalid   <= 1'b1;
          m_tdata    <= skid_data;
          m_tlast    <= skid_last;
          skid_valid <= 1'b0;
        end else if (adv && res_valid) begin
          m_tvalid <= 1'b1;
          m_tdata  <= res_data;
          m_tlast  <= b_last;
        end else begin
          m_tvalid <= 1'b0;
        end
      end else if (adv && res_valid) begin
        skid_valid <= 1'b1;
        skid_data  <= res_data;
        skid_last  <= b_last;
      end
    end
  end

endmodule

// ===== hdl/pmd_line_store.sv =====
// Line store of horizontal pair sums, registered read with write forwarding.
module pmd_line_store #(
  parameter int DEPTH = pmd_pkg::MAX_WIDTH_DEF / 2,
  parameter int AW    = 11,
  parameter int DW    = pmd_pkg::PAIR_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_q;
  logic [DW-1:0] fwd_q;
  logic          hit_q;

  always_ff @(posedge clk) begin
    if (en) begin
      if (wr_en) begin
        mem[wr_addr] <= wr_data;
      end
      rd_q <= mem[rd_addr];
    end
  end

  // Read and write of the same entry in the same cycle: take the new data.
  always_ff @(posedge clk) begin
    if (en) begin
      hit_q <= wr_en && (wr_addr == rd_addr);
      fwd_q <= wr_data;
    end
  end

  assign rd_data = hit_q ? fwd_q : rd_q;

endmodule

// ===== hdl/pmd_checker.sv =====
// Port-level checks of the mip downsampler, bound to the top level.
`include "premultiply_mip_downsampler_core_defines.svh"

module pmd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tlast
);

  // Input only stalls behind a held output transaction.
  `PMD_ASSERT(a_stall_needs_held_out, (!s_tready |-> m_tvalid))
  `PMD_ASSERT(a_stall_starts_on_backpressure, ($fell(s_tready) |-> $past(m_tvalid && !m_tready)))
  `PMD_ASSERT(a_out_held, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
  `PMD_ASSERT_ALWAYS(a_reset_clears, (rst |=> !m_tvalid && s_tready))

endmodule

bind premultiply_mip_downsampler_core pmd_checker u_pmd_checker (.*);

// ===== bench/pmd_frame_checker.sv =====
// Scoreboard for the mip downsampler: predicts each output pixel and checks the master stream.
`timescale 1ns / 100ps

module pmd_frame_checker #(
  parameter int MAX_WIDTH = pmd_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [31:0]                    s_tdata,  // pixel_in[31:0]
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [55:0]                    m_tdata,  // pixel_out, out_column, out_row, pad
  input  logic                           m_tlast,  // frame_last
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending_count,
  output int                             result_count
);

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;

  typedef struct packed {
    logic [31:0]                 px;
    logic [pmd_pkg::COORD_W-1:0] col;
    logic [pmd_pkg::COORD_W-1:0] row;
    logic                        last;
  } mip_px_t;

  mip_px_t                        mip_expected_q[$];
  logic [pmd_pkg::PAIR_W-1:0]     top_pairs [LINE_DEPTH];
  logic [31:0]                    held_px;
  int unsigned                    col;
  int unsigned                    row;
  logic [pmd_pkg::CFG_DATA_W-1:0] width_reg;
  logic [pmd_pkg::CFG_DATA_W-1:0] height_reg;
  logic                           premul_on;

  function automatic logic [31:0] premul(input logic [31:0] p);
    int unsigned a;
    int unsigned ch;
    logic [31:0] r;
    a = 32'(p[31:24]);
    if (a == 255) return p;
    r = {p[31:24], 24'd0};
    for (int i = 0; i < 3; i++) begin
      ch = 32'(p[8*i +: 8]);
      r[8*i +: 8] = 8'((ch * a + 127) / 255);
    end
    return r;
  endfunction

  function automatic logic [pmd_pkg::PAIR_W-1:0] pair_sums(input logic [31:0] l,
                                                           input logic [31:0] r);
    logic [pmd_pkg::PAIR_W-1:0] s;
    int unsigned v;
    s = '0;
    for (int i = 0; i < 4; i++) begin
      v = 32'(l[8*i +: 8]) + 32'(r[8*i +: 8]);
      s[9*i +: 9] = v[8:0];
    end
    return s;
  endfunction

  function automatic logic [31:0] box_mean(input logic [pmd_pkg::PAIR_W-1:0] t,
                                           input logic [pmd_pkg::PAIR_W-1:0] b);
    logic [31:0] m;
    int unsigned v;
    m = '0;
    for (int i = 0; i < 4; i++) begin
      v = (32'(t[9*i +: 9]) + 32'(b[9*i +: 9]) + 2) / 4;
      m[8*i +: 8] = v[7:0];
    end
    return m;
  endfunction

  task automatic apply_write(input logic [pmd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pmd_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      pmd_pkg::REG_IMAGE_WIDTH:  width_reg = val;
      pmd_pkg::REG_IMAGE_HEIGHT: height_reg = val;
      pmd_pkg::REG_PREMULTIPLY:  premul_on = val[0];
      default: return;
    endcase
    // any real write restarts the frame
    col = 0;
    row = 0;
    held_px = '0;
  endtask

  task automatic take_pixel(input logic [31:0] raw);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    logic [31:0] px;
    logic [31:0] left;
    logic [pmd_pkg::PAIR_W-1:0] sums;
    logic [pmd_pkg::PAIR_W-1:0] upper;
    mip_px_t e;
    w = (width_reg == '0) ? 1 :
        ((int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
    h = (height_reg == '0) ? 1 :
        ((int'(height_reg) > pmd_pkg::MAX_HEIGHT) ? pmd_pkg::MAX_HEIGHT : int'(height_reg));
    x = col;
    y = row;
    if (x >= w || y >= h) begin
      x = 0;
      y = 0;
    end
    px = premul_on ? premul(raw) : raw;
    if (!x[0] && x != w - 1) begin
      held_px = px;
    end else begin
      // odd last column pairs the edge pixel with itself
      left = x[0] ? held_px : px;
      sums = pair_sums(left, px);
      if (!y[0] && y != h - 1) begin
        top_pairs[(x >> 1) % LINE_DEPTH] = sums;
      end else begin
        upper = y[0] ? top_pairs[(x >> 1) % LINE_DEPTH] : sums;
        e.px   = box_mean(upper, sums);
        e.col  = x[pmd_pkg::COORD_W:1];
        e.row  = y[pmd_pkg::COORD_W:1];
        e.last = (x == w - 1 && y == h - 1);
        mip_expected_q = {mip_expected_q, e};
      end
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col = x;
    row = y;
  endtask

  task automatic check_result();
    mip_px_t want;
    result_count++;
    if (mip_expected_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected output pixel %h col %0d row %0d last %b", $realtime,
                 m_tdata[31:0], m_tdata[42:32], m_tdata[53:43], m_tlast);
    end else begin
      want = mip_expected_q.pop_front();
      if (m_tdata[31:0] !== want.px || m_tdata[42:32] !== want.col ||
          m_tdata[53:43] !== want.row || m_tlast !== want.last) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"%0t: mismatch, expected px %h col %0d row %0d last %b, ",
                    "got px %h col %0d row %0d last %b"},
                   $realtime, want.px, want.col, want.row, want.last,
                   m_tdata[31:0], m_tdata[42:32], m_tdata[53:43], m_tlast);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mip_expected_q.delete();
      col = 0;
      row = 0;
      held_px = '0;
      width_reg = 1;
      height_reg = 1;
      premul_on = 1'b1;
      fail_count = 0;
      result_count = 0;
      pending_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (s_tvalid && s_tready) take_pixel(s_tdata);
      if (m_tvalid && m_tready) check_result();
      pending_count <= mip_expected_q.size();
    end
  end

endmodule

// ===== bench/tb_premultiply_mip_downsampler_core.sv =====
// Testbench top: drives pixel frames and register writes into the mip downsampler.
`timescale 1ns / 100ps

module tb_premultiply_mip_downsampler_core;

  localparam int unsigned RANDOM_PIXELS = 500;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned EDGE_RUN      = 24;
  localparam logic [pmd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind this index

  localparam int N_CORNER = 9;
  localparam logic [31:0] CORNER_PX [N_CORNER] = '{
    32'hffffffff, 32'h00ffffff, 32'h7f808080,
    32'h01ff00ff, 32'h80ffffff, 32'hfe010203,
    32'h00000000, 32'hff123456, 32'h40ffffff
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [31:0]                    s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [55:0]                    m_tdata;
  logic                           m_tlast;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [pmd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pmd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int          fail_count;
  int          pending_count;
  int          result_count;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned reg_writes = 0;

  premultiply_mip_downsampler_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pmd_frame_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // output side back-pressure
  always @(posedge clk) begin
    if (stall_pct == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // valid stays high between back-to-back pixels; it drops only on a gap
  task automatic send_pixel(input logic [31:0] px);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  // idle the sender until nothing is owed and the pipeline has emptied
  task automatic drain_outputs();
    int unsigned quiet;
    s_tvalid <= 1'b0;
    quiet = 0;
    while (quiet < SETTLE_CYCLES) begin
      @(posedge clk);
      quiet = (pending_count == 0) ? quiet + 1 : 0;
    end
  endtask

  task automatic write_reg(input logic [pmd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pmd_pkg::CFG_DATA_W-1:0] val);
    drain_outputs();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin
        gap_pct   = 12;
        stall_pct = 55;
      end
      1: begin
        gap_pct   = 55;
        stall_pct = 12;
      end
      default: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    p = $urandom;
    case ($urandom_range(5))
      0: p[31:24] = 8'h00;
      1: p[31:24] = 8'hff;
      2: p[23:0]  = 24'hffffff;
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_frame(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_pixel(rand_pixel());
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned frames;
    int unsigned random_pixels;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset configuration is a 1x1 premultiplied frame: each pixel is its own level
    send_pixel(32'h80ff4020);
    send_pixel(32'hffffffff);
    send_pixel(32'h00ffffff);
    send_pixel(32'h00000000);
    frames_sent += 4;

    write_reg(REG_SPARE, '1);
    // 3x3 exercises the odd last column and odd last row together
    write_reg(pmd_pkg::REG_IMAGE_WIDTH, 13'd3);
    write_reg(pmd_pkg::REG_IMAGE_HEIGHT, 13'd3);
    for (int i = 0; i < N_CORNER; i++) send_pixel(CORNER_PX[i]);
    frames_sent++;

    // zero sizes behave as one
    write_reg(pmd_pkg::REG_IMAGE_WIDTH, '0);
    write_reg(pmd_pkg::REG_IMAGE_HEIGHT, '0);
    send_pixel(32'h7fff00aa);
    send_pixel(32'h01010101);
    frames_sent += 2;

    write_reg(pmd_pkg::REG_PREMULTIPLY, 13'd0);
    write_reg(pmd_pkg::REG_IMAGE_WIDTH, 13'd2);
    write_reg(pmd_pkg::REG_IMAGE_HEIGHT, 13'd2);
    send_pixel(32'hffffffff);
    send_pixel(32'hffffffff);
    send_pixel(32'h00000000);
    send_pixel(32'h01020304);
    frames_sent++;

    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      set_idling(random_pixels * 3 / RANDOM_PIXELS);
      if ($urandom_range(7) == 0) begin
        w = $urandom_range(20, 48);
        h = $urandom_range(1, 3);
      end else begin
        w = $urandom_range(1, 9);
        h = $urandom_range(1, 6);
      end
      if ($urandom_range(9) == 0) write_reg(REG_SPARE, 13'($urandom_range(0, 8191)));
      write_reg(pmd_pkg::REG_IMAGE_WIDTH, 13'(w));
      write_reg(pmd_pkg::REG_IMAGE_HEIGHT, 13'(h));
      write_reg(pmd_pkg::REG_PREMULTIPLY,
                {12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1))});
      frames = $urandom_range(1, 2);
      for (int unsigned f = 0; f < frames; f++) begin
        n = w * h;
        // now and then cut a frame short; the next write restarts it
        if (n > 1 && $urandom_range(9) == 0) n = $urandom_range(1, n - 1);
        send_frame(n);
        random_pixels += n;
        frames_sent++;
      end
    end

    // oversize registers saturate to the largest image; a short run into a full-width
    // row and a full-height column, the first restarted by the following write
    set_idling(2);
    write_reg(pmd_pkg::REG_IMAGE_WIDTH, '1);
    write_reg(pmd_pkg::REG_IMAGE_HEIGHT, 13'd1);
    write_reg(pmd_pkg::REG_PREMULTIPLY, 13'd1);
    send_frame(EDGE_RUN);
    write_reg(pmd_pkg::REG_IMAGE_WIDTH, 13'd1);
    write_reg(pmd_pkg::REG_IMAGE_HEIGHT, '1);
    write_reg(pmd_pkg::REG_PREMULTIPLY, 13'd0);
    send_frame(EDGE_RUN);
    frames_sent += 2;

    drain_outputs();
    $display("covered %0d pixels in %0d frames with %0d register writes", pixels_sent,
             frames_sent, reg_writes);
    $display("checked %0d output pixels, %0d still owed", result_count, pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== premultiply_mip_downsampler_core.f =====
+incdir+hdl
hdl/pmd_pkg.sv
hdl/pmd_line_store.sv
hdl/premultiply_mip_downsampler_core.sv
hdl/pmd_checker.sv
bench/pmd_frame_checker.sv
bench/tb_premultiply_mip_downsampler_core.sv
